// ===== hdl/ksd_pkg.sv =====
package ksd_pkg;

    localparam int ROWS      = 2;
    localparam int COLUMNS   = 4;

    localparam int TIME_W    = 48;
    localparam int WINDOW_W  = 20;
    localparam int LEVEL_W   = 4;
    localparam int CODE_W    = 7;
    localparam int COL_W     = 2;
    localparam int ROW_W     = 1;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(20000);
    localparam logic [TIME_W-1:0]   TIME_MAX     = {TIME_W{1'b1}};

    typedef logic [TIME_W-1:0] t_time;

    // Debounce state of the keys of one row.
    typedef struct packed {
        logic [COLUMNS-1:0]             pressed;
        logic [COLUMNS-1:0][TIME_W-1:0] deadline;
    } t_row_state;

    typedef struct packed {
        logic              found;
        logic [CODE_W-1:0] code;
        logic [COL_W-1:0]  column;
    } t_key_result;

    typedef logic [7:0] t_symbol_row [4];
    localparam t_symbol_row KEY_SYMBOLS [4] = '{
        '{8'h31, 8'h32, 8'h33, 8'h41},   // 1 2 3 A
        '{8'h34, 8'h35, 8'h36, 8'h42},   // 4 5 6 B
        '{8'h37, 8'h38, 8'h39, 8'h43},   // 7 8 9 C
        '{8'h2A, 8'h30, 8'h23, 8'h44}    // * 0 # D
    };

    function automatic logic [CODE_W-1:0] key_symbol(input logic [1:0] row,
                                                      input logic [1:0] col);
        logic [7:0] sym;
        sym = KEY_SYMBOLS[row][col];
        return sym[CODE_W-1:0];
    endfunction

endpackage

// ===== hdl/ksd_key_state.sv =====
module ksd_key_state (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [ksd_pkg::ROW_W-1:0] i_rd_row,
    output ksd_pkg::t_row_state       o_rd_state,
    input  logic                      i_wr_en,
    input  logic [ksd_pkg::ROW_W-1:0] i_wr_row,
    input  ksd_pkg::t_row_state       i_wr_state
);
    import ksd_pkg::*;

    t_row_state r_rows [ROWS];

    // Flop array: eight keys, cleared to released with zero deadlines.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_rows[r] <= '0;
            end
        end else if (i_wr_en) begin
            r_rows[i_wr_row] <= i_wr_state;
        end
    end

    assign o_rd_state = r_rows[i_rd_row];

endmodule

// ===== hdl/ksd_row_update.sv =====
module ksd_row_update (
    input  logic [ksd_pkg::ROW_W-1:0]    i_row,
    input  logic [ksd_pkg::LEVEL_W-1:0]  i_levels,
    input  ksd_pkg::t_time               i_now,
    input  logic [ksd_pkg::WINDOW_W-1:0] i_window,
    input  ksd_pkg::t_row_state          i_state,
    output ksd_pkg::t_row_state          o_state,
    output ksd_pkg::t_key_result         o_result
);
    import ksd_pkg::*;

    logic [TIME_W:0] sum;
    t_time           rearm;

    // Saturating now + window.
    assign sum   = {1'b0, i_now} + (TIME_W+1)'(i_window);
    assign rearm = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

    always_comb begin
        logic done;
        logic pressed;
        done     = 1'b0;
        o_state  = i_state;
        o_result = '0;
        for (int c = 0; c < COLUMNS; c++) begin
            pressed = ~i_levels[c];
            if (!done) begin
                if (pressed != i_state.pressed[c]) begin
                    o_state.deadline[c] = rearm;
                    if (i_now >= i_state.deadline[c]) begin
                        o_state.pressed[c] = pressed;
                        if (pressed) begin
                            done            = 1'b1;
                            o_result.found  = 1'b1;
                            o_result.code   = key_symbol(2'(i_row), COL_W'(c));
                            o_result.column = COL_W'(c);
                        end
                    end
                end else if (i_now > i_state.deadline[c]) begin
                    o_state.deadline[c] = i_now;
                end
            end
        end
    end

endmodule

// ===== hdl/keypad_scan_debounce.sv =====
// Debounced matrix keypad scanner. Each input transaction is one row sample:
// the row being driven low, the four active-low column levels (0 = pressed)
// and a free-running microsecond timestamp. Every key keeps a debounced state
// and a hold deadline; a changed level is taken only once the deadline has
// been reached, and either way the change pushes the deadline out by the
// debounce window. The first newly pressed key of a sample (lowest column
// first) is reported with its keypad ASCII code and column, and later columns
// of that sample are left untouched. Exactly one result transaction follows
// every input transaction. Rate: one transaction per clock unless stalled;
// the per-row update with its 48-bit compares and the saturating deadline
// add sits between the input register and the result register. The debounce
// window (reset 20000 us) is written through i_cfg_we/i_cfg_wdata and must
// only change while no transaction is in flight.
module keypad_scan_debounce (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ksd_pkg::WINDOW_W-1:0] i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [ksd_pkg::ROW_W-1:0]    i_row_index,
    input  logic [ksd_pkg::LEVEL_W-1:0]  i_column_levels,
    input  logic [ksd_pkg::TIME_W-1:0]   i_time_now,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_key_found,
    output logic [ksd_pkg::CODE_W-1:0]   o_key_code,
    output logic [ksd_pkg::COL_W-1:0]    o_key_column
);
    import ksd_pkg::*;

    logic [WINDOW_W-1:0] r_window;

    logic                r_in_valid;
    logic [ROW_W-1:0]    r_row;
    logic [LEVEL_W-1:0]  r_levels;
    t_time               r_now;

    logic                r_out_valid;
    t_key_result         r_result;

    logic                accept;
    logic                advance;
    logic                row_ok;
    t_row_state          cur_state;
    t_row_state          n_state;
    t_key_result         n_result;

    // Move the held sample into the result stage whenever that stage is free
    // or being drained this cycle; the key state is written at the same edge.
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;
    assign row_ok  = 32'(r_row) < ROWS;

    // Debounce window register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_wdata;
        end
    end

    // Input register: hold the sample while the result stage is blocked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row    <= i_row_index;
            r_levels <= i_column_levels;
            r_now    <= i_time_now;
        end
    end

    ksd_key_state u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_row   (r_row),
        .o_rd_state (cur_state),
        .i_wr_en    (advance && row_ok),
        .i_wr_row   (r_row),
        .i_wr_state (n_state)
    );

    ksd_row_update u_update (
        .i_row    (r_row),
        .i_levels (r_levels),
        .i_now    (r_now),
        .i_window (r_window),
        .i_state  (cur_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Result register: drop the result once taken downstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= row_ok ? n_result : '0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_key_found  = r_result.found;
    assign o_key_code   = r_result.code;
    assign o_key_column = r_result.column;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled without a blocked pending sample");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result stage empty after an advance");

    a_no_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_key_found |-> o_key_code == '0 && o_key_column == '0)
        else $error("code or column set without a key");

    a_key_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_key_found |-> o_key_code != '0)
        else $error("reported key with empty code");

endmodule
